// ===== rtl/range_add_range_sum_tree_macros.svh =====
// Assertion macros used by the checker file.
`ifndef RANGE_ADD_RANGE_SUM_TREE_MACROS_SVH
`define RANGE_ADD_RANGE_SUM_TREE_MACROS_SVH

// Check that cons holds in the cycle after ante.
`define RARST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("range sum tree check failed");

// Check that cons holds in the same cycle as ante.
`define RARST_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("range sum tree check failed");

`endif

// ===== rtl/rarst_pkg.sv =====
`default_nettype none

package rarst_pkg;

    localparam int unsigned IDX_W      = 10;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned LEAVES_DEF = 1024;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [DATA_W-1:0] t_data;

    // Command codes
    localparam t_cmd CMD_ADD   = 2'd0;
    localparam t_cmd CMD_FINAL = 2'd1;
    localparam t_cmd CMD_QUERY = 2'd2;
    localparam t_cmd CMD_CLEAR = 2'd3;

    // Status codes
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_REFUSED = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/rarst_span.sv =====
`default_nettype none

// Turn a pair of cell indices into the half-open node span [lo, hi) that
// the bottom-up tree walk starts from.
module rarst_span #(
    parameter int unsigned LEAVES = rarst_pkg::LEAVES_DEF,
    parameter int unsigned AW     = $clog2(2 * LEAVES) + 1
) (
    input  rarst_pkg::t_idx i_left_index,
    input  rarst_pkg::t_idx i_right_index,
    output logic [AW-1:0]   o_lo_node,
    output logic [AW-1:0]   o_hi_bound
);
    import rarst_pkg::*;

    localparam int unsigned XW = (AW > IDX_W) ? AW : IDX_W;
    localparam logic [XW-1:0] LAST_CELL = XW'(LEAVES - 1);

    logic [XW-1:0] left_x;
    logic [XW-1:0] right_x;
    logic [XW-1:0] left_c;
    logic [XW-1:0] right_c;
    logic [XW-1:0] lo_x;
    logic [XW-1:0] hi_x;

    // Saturate indices past the last cell
    assign left_x  = XW'(i_left_index);
    assign right_x = XW'(i_right_index);
    assign left_c  = (left_x > LAST_CELL) ? LAST_CELL : left_x;
    assign right_c = (right_x > LAST_CELL) ? LAST_CELL : right_x;

    // Order the bounds
    assign lo_x = (left_c > right_c) ? right_c : left_c;
    assign hi_x = (left_c > right_c) ? left_c : right_c;

    // Move to leaf node numbers, upper bound exclusive
    assign o_lo_node  = AW'(lo_x) + AW'(LEAVES);
    assign o_hi_bound = AW'(hi_x) + AW'(LEAVES) + AW'(1);

endmodule

`default_nettype wire

// ===== rtl/range_add_range_sum_tree.sv =====
// Range add / range sum over LEAVES cells, one single-port-read tree memory.
// Range add or query: one memory read per visited node, with a write back for
//   an add, from acceptance to result.
// Finalize: push pending adds down from the root, then build subtree sums.
// Clear and reset: a wipe of every node with no transaction accepted.
// One item in flight; the result register frees the input side at once.
`default_nettype none

module range_add_range_sum_tree #(
    parameter int unsigned LEAVES = rarst_pkg::LEAVES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rarst_pkg::t_cmd  i_command,
    input  rarst_pkg::t_idx  i_left_index,
    input  rarst_pkg::t_idx  i_right_index,
    input  rarst_pkg::t_data i_addend,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output rarst_pkg::t_data o_range_sum,
    output logic             o_status
);
    import rarst_pkg::*;

    localparam int unsigned NODES = 2 * LEAVES;
    localparam int unsigned NW    = $clog2(NODES);
    localparam int unsigned AW    = NW + 1;

    localparam logic [NW-1:0] NODE_ONE  = NW'(1);
    localparam logic [NW-1:0] NODE_TOP  = NW'(LEAVES - 1);
    localparam logic [NW-1:0] NODE_LAST = NW'(NODES - 1);

    // Sequencer states
    localparam int unsigned SW = 4;
    localparam logic [SW-1:0] S_IDLE     = 4'd0;
    localparam logic [SW-1:0] S_WIPE     = 4'd1;
    localparam logic [SW-1:0] S_RNG_A    = 4'd2;
    localparam logic [SW-1:0] S_RNG_AD   = 4'd3;
    localparam logic [SW-1:0] S_RNG_B    = 4'd4;
    localparam logic [SW-1:0] S_RNG_BD   = 4'd5;
    localparam logic [SW-1:0] S_PUSH_RD  = 4'd6;
    localparam logic [SW-1:0] S_PUSH_PAR = 4'd7;
    localparam logic [SW-1:0] S_PUSH_L   = 4'd8;
    localparam logic [SW-1:0] S_PUSH_R   = 4'd9;
    localparam logic [SW-1:0] S_BLD_L    = 4'd10;
    localparam logic [SW-1:0] S_BLD_LD   = 4'd11;
    localparam logic [SW-1:0] S_BLD_R    = 4'd12;
    localparam logic [SW-1:0] S_DONE     = 4'd13;

    // Tree store: pending adds while loading, subtree sums after finalize
    t_data r_tree_mem [NODES];
    t_data r_rdata;

    logic          mem_we;
    logic [NW-1:0] mem_waddr;
    t_data         mem_wdata;
    logic [NW-1:0] mem_raddr;

    // Control registers
    logic [SW-1:0] r_state, n_state;
    logic          r_phase, n_phase;
    logic          r_wipe_reply, n_wipe_reply;
    logic [NW-1:0] r_i, n_i;
    logic          r_out_valid, n_out_valid;

    // Payload registers
    logic [AW-1:0] r_a, n_a;
    logic [AW-1:0] r_b, n_b;
    t_data         r_addend, n_addend;
    t_data         r_acc, n_acc;
    t_data         r_par, n_par;
    logic          r_is_query, n_is_query;
    logic          r_refused, n_refused;
    t_data         r_range_sum, n_range_sum;
    logic          r_status, n_status;

    logic [AW-1:0] span_lo;
    logic [AW-1:0] span_hi;
    logic [AW-1:0] b_dec;
    logic [NW-1:0] left_child;
    logic [NW-1:0] right_child;
    logic          out_free;

    rarst_span #(
        .LEAVES (LEAVES),
        .AW     (AW)
    ) u_span (
        .i_left_index  (i_left_index),
        .i_right_index (i_right_index),
        .o_lo_node     (span_lo),
        .o_hi_bound    (span_hi)
    );

    assign b_dec       = r_b - AW'(1);
    assign left_child  = {r_i[NW-2:0], 1'b0};
    assign right_child = {r_i[NW-2:0], 1'b1};
    assign out_free    = !r_out_valid || i_out_ready;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_range_sum = r_range_sum;
    assign o_status    = r_status;

    // Sequence memory accesses for each command
    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_wipe_reply = r_wipe_reply;
        n_i          = r_i;
        n_a          = r_a;
        n_b          = r_b;
        n_addend     = r_addend;
        n_acc        = r_acc;
        n_par        = r_par;
        n_is_query   = r_is_query;
        n_refused    = r_refused;
        n_range_sum  = r_range_sum;
        n_status     = r_status;
        n_out_valid  = i_out_ready ? 1'b0 : r_out_valid;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_raddr    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_a        = span_lo;
                    n_b        = span_hi;
                    n_addend   = i_addend;
                    n_acc      = '0;
                    n_refused  = ST_OK;
                    n_is_query = (i_command == CMD_QUERY);
                    unique case (i_command)
                        CMD_ADD: begin
                            if (r_phase) begin
                                n_refused = ST_REFUSED;
                                n_state   = S_DONE;
                            end else begin
                                n_state = S_RNG_A;
                            end
                        end
                        CMD_FINAL: begin
                            if (r_phase) begin
                                n_refused = ST_REFUSED;
                                n_state   = S_DONE;
                            end else begin
                                n_i     = NODE_ONE;
                                n_state = S_PUSH_RD;
                            end
                        end
                        CMD_QUERY: begin
                            if (!r_phase) begin
                                n_refused = ST_REFUSED;
                                n_state   = S_DONE;
                            end else begin
                                n_state = S_RNG_A;
                            end
                        end
                        CMD_CLEAR: begin
                            n_phase      = 1'b0;
                            n_i          = '0;
                            n_wipe_reply = 1'b1;
                            n_state      = S_WIPE;
                        end
                    endcase
                end
            end

            // Zero one node a cycle
            S_WIPE: begin
                mem_we    = 1'b1;
                mem_waddr = r_i;
                mem_wdata = '0;
                if (r_i == NODE_LAST) begin
                    n_wipe_reply = 1'b0;
                    n_state      = r_wipe_reply ? S_DONE : S_IDLE;
                end else begin
                    n_i = r_i + NW'(1);
                end
            end

            // Left edge of the span at this level
            S_RNG_A: begin
                if (r_a < r_b) begin
                    if (r_a[0]) begin
                        mem_raddr = r_a[NW-1:0];
                        n_state   = S_RNG_AD;
                    end else begin
                        n_state = S_RNG_B;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end

            S_RNG_AD: begin
                if (r_is_query) begin
                    n_acc = r_acc + r_rdata;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_a[NW-1:0];
                    mem_wdata = r_rdata + r_addend;
                end
                n_a     = r_a + AW'(1);
                n_state = S_RNG_B;
            end

            // Right edge of the span at this level
            S_RNG_B: begin
                if (r_b[0]) begin
                    n_b       = b_dec;
                    mem_raddr = b_dec[NW-1:0];
                    n_state   = S_RNG_BD;
                end else begin
                    n_a     = r_a >> 1;
                    n_b     = r_b >> 1;
                    n_state = S_RNG_A;
                end
            end

            S_RNG_BD: begin
                if (r_is_query) begin
                    n_acc = r_acc + r_rdata;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_b[NW-1:0];
                    mem_wdata = r_rdata + r_addend;
                end
                n_a     = r_a >> 1;
                n_b     = r_b >> 1;
                n_state = S_RNG_A;
            end

            // Push pending adds down, root first
            S_PUSH_RD: begin
                mem_raddr = r_i;
                n_state   = S_PUSH_PAR;
            end

            S_PUSH_PAR: begin
                n_par     = r_rdata;
                mem_raddr = left_child;
                n_state   = S_PUSH_L;
            end

            S_PUSH_L: begin
                mem_we    = 1'b1;
                mem_waddr = left_child;
                mem_wdata = r_rdata + r_par;
                mem_raddr = right_child;
                n_state   = S_PUSH_R;
            end

            S_PUSH_R: begin
                mem_we    = 1'b1;
                mem_waddr = right_child;
                mem_wdata = r_rdata + r_par;
                if (r_i == NODE_TOP) begin
                    n_state = S_BLD_L;
                end else begin
                    n_i       = r_i + NW'(1);
                    mem_raddr = r_i + NW'(1);
                    n_state   = S_PUSH_PAR;
                end
            end

            // Build subtree sums, last inner node first
            S_BLD_L: begin
                mem_raddr = left_child;
                n_state   = S_BLD_LD;
            end

            S_BLD_LD: begin
                n_par     = r_rdata;
                mem_raddr = right_child;
                n_state   = S_BLD_R;
            end

            S_BLD_R: begin
                mem_we    = 1'b1;
                mem_waddr = r_i;
                mem_wdata = r_par + r_rdata;
                if (r_i == NODE_ONE) begin
                    n_phase = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_i     = r_i - NW'(1);
                    n_state = S_BLD_L;
                end
            end

            // Hand the result to the output register
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_range_sum = r_acc;
                    n_status    = r_refused;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Tree memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_tree_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_tree_mem[mem_raddr];
    end

    // Control state, wipe the store after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_WIPE;
            r_phase      <= 1'b0;
            r_wipe_reply <= 1'b0;
            r_i          <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_wipe_reply <= n_wipe_reply;
            r_i          <= n_i;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_a         <= n_a;
        r_b         <= n_b;
        r_addend    <= n_addend;
        r_acc       <= n_acc;
        r_par       <= n_par;
        r_is_query  <= n_is_query;
        r_refused   <= n_refused;
        r_range_sum <= n_range_sum;
        r_status    <= n_status;
    end

endmodule

`default_nettype wire

// ===== rtl/rarst_chk.sv =====
`default_nettype none

`include "range_add_range_sum_tree_macros.svh"

// Port-level checks on the range sum tree.
module rarst_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input rarst_pkg::t_data o_range_sum,
    input logic             o_status
);
    import rarst_pkg::*;

    // Hold a stalled result
    `RARST_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `RARST_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_range_sum) && $stable(o_status))

    // Take one transaction at a time
    `RARST_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // Refused commands carry no sum
    `RARST_ASSERT_NOW(a_refused_zero, i_clk, i_rst_n, o_out_valid && (o_status == ST_REFUSED), o_range_sum == '0)

    // Drop both handshakes while the store is wiped after reset
    `RARST_ASSERT_NEXT(a_reset_quiet, i_clk, 1'b1, !i_rst_n, !o_out_valid && !o_in_ready)

endmodule

bind range_add_range_sum_tree rarst_chk u_rarst_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_range_sum (o_range_sum),
    .o_status    (o_status)
);

`default_nettype wire

// ===== tb/range_sum_checker.sv =====
`timescale 1ns / 1ps

module range_sum_checker #(
    parameter int unsigned LEAVES = rarst_pkg::LEAVES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  rarst_pkg::t_cmd  i_command,
    input  rarst_pkg::t_idx  i_left_index,
    input  rarst_pkg::t_idx  i_right_index,
    input  rarst_pkg::t_data i_addend,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  rarst_pkg::t_data i_range_sum,
    input  logic             i_status,
    output int               o_fail_count,
    output int               o_outstanding
);
    import rarst_pkg::*;

    typedef struct packed {
        t_data range_sum;
        logic  status;
    } t_tree_reply;

    // Flat image of the cells: once pending adds are pushed down, every leaf
    // holds the wrapped sum of the adds covering it, and any node sum is the
    // wrapped sum of its leaves, so a flat array gives the same answers.
    t_data       cell_value [LEAVES];
    logic        query_phase;
    t_tree_reply replies_due [$];
    int          fail_total = 0;

    assign o_fail_count = fail_total;

    // Apply one command to the cell image and return the reply it produces
    function automatic t_tree_reply apply_command(input t_cmd cmd, input t_idx left,
                                                  input t_idx right, input t_data addend);
        t_tree_reply reply;
        int unsigned lo;
        int unsigned hi;
        int unsigned tmp;
        int unsigned c;
        reply.range_sum = '0;
        reply.status    = ST_OK;
        // saturate indices past the last cell, then order the bounds
        lo = (left >= LEAVES) ? LEAVES - 1 : left;
        hi = (right >= LEAVES) ? LEAVES - 1 : right;
        if (lo > hi) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        case (cmd)
            CMD_ADD: begin
                if (query_phase) begin
                    reply.status = ST_REFUSED;
                end else begin
                    for (c = lo; c <= hi; c++) cell_value[c] += addend;
                end
            end
            CMD_FINAL: begin
                if (query_phase) reply.status = ST_REFUSED;
                else query_phase = 1'b1;
            end
            CMD_QUERY: begin
                if (!query_phase) begin
                    reply.status = ST_REFUSED;
                end else begin
                    for (c = lo; c <= hi; c++) reply.range_sum += cell_value[c];
                end
            end
            default: begin
                for (c = 0; c < LEAVES; c++) cell_value[c] = '0;
                query_phase = 1'b0;
            end
        endcase
        return reply;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_tree_reply oldest;
        int unsigned c;
        if (!i_rst_n) begin
            for (c = 0; c < LEAVES; c++) cell_value[c] = '0;
            query_phase = 1'b0;
            replies_due.delete();
            o_outstanding <= 0;
        end else begin
            // retire the oldest transaction first; its reply cannot share an edge
            // with its own request
            if (i_out_valid && i_out_ready) begin
                if (replies_due.size() == 0) begin
                    $error("result transaction with none outstanding: range_sum %h status %b",
                           i_range_sum, i_status);
                    fail_total++;
                end else begin
                    oldest = replies_due.pop_front();
                    if (i_range_sum !== oldest.range_sum) begin
                        $error("range_sum mismatch: expected %h, actual %h",
                               oldest.range_sum, i_range_sum);
                        fail_total++;
                    end
                    if (i_status !== oldest.status) begin
                        $error("status mismatch: expected %b, actual %b",
                               oldest.status, i_status);
                        fail_total++;
                    end
                end
            end
            // predict the reply for each accepted request
            if (i_in_valid && i_in_ready) begin
                replies_due.push_back(apply_command(i_command, i_left_index,
                                                    i_right_index, i_addend));
            end
            o_outstanding <= replies_due.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import rarst_pkg::*;

    localparam int unsigned LEAVES      = LEAVES_DEF;
    localparam int unsigned STALL_LIMIT = 50000;
    localparam int unsigned PHASE_ITEMS = 100;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  in_ready;
    t_cmd  command   = CMD_ADD;
    t_idx  left_idx  = '0;
    t_idx  right_idx = '0;
    t_data addend    = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    t_data range_sum;
    logic  status;
    int    fail_count;
    int    outstanding;

    int unsigned send_idle_pct   = 0;
    int unsigned recv_stall_pct  = 0;
    int unsigned items_in_phase  = 0;
    int unsigned stall_run       = 0;
    int unsigned send_pcts [4]   = '{0, 85, 0, 18};
    int unsigned recv_pcts [4]   = '{0, 0, 85, 18};

    range_add_range_sum_tree #(
        .LEAVES (LEAVES)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_command     (command),
        .i_left_index  (left_idx),
        .i_right_index (right_idx),
        .i_addend      (addend),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_range_sum   (range_sum),
        .o_status      (status)
    );

    range_sum_checker #(
        .LEAVES (LEAVES)
    ) checker_inst (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_command     (command),
        .i_left_index  (left_idx),
        .i_right_index (right_idx),
        .i_addend      (addend),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_range_sum   (range_sum),
        .i_status      (status),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Stall the result side at the current rate
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Abort when no transaction moves for too long
    initial begin
        do begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) stall_run = 0;
            else stall_run++;
        end while (stall_run < STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Present one request after a random gap and hold it until accepted
    task automatic issue_command(input t_cmd cmd, input t_idx lo, input t_idx hi,
                                 input t_data value);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        left_idx  <= lo;
        right_idx <= hi;
        addend    <= value;
        do @(posedge clk); while (!in_ready);
        items_in_phase++;
    endtask

    // Hold off the request side until every reply has come back
    task automatic drain_replies();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    function automatic void pick_range(output t_idx lo, output t_idx hi);
        t_idx tmp;
        case ($urandom_range(4))
            0: begin
                lo = '0;
                hi = '1;
            end
            1: begin
                lo = t_idx'($urandom);
                hi = lo;
            end
            2: begin
                // narrow range; the wrap past the top end gives swapped bounds
                lo = t_idx'($urandom);
                hi = lo + t_idx'($urandom_range(7));
            end
            3: begin
                lo = $urandom_range(1) ? '1 : '0;
                hi = t_idx'($urandom);
            end
            default: begin
                lo = t_idx'($urandom);
                hi = t_idx'($urandom);
            end
        endcase
        if ($urandom_range(3) == 0) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
    endfunction

    function automatic t_data pick_addend();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return t_data'($urandom_range(15));
            default: return t_data'($urandom);
        endcase
    endfunction

    task automatic issue_noise();
        issue_command(t_cmd'($urandom_range(3)), t_idx'($urandom), t_idx'($urandom),
                      t_data'($urandom));
    endtask

    // One load / finalize / query round, with the odd stray or missing step
    task automatic run_session();
        int unsigned n_adds;
        int unsigned n_queries;
        int unsigned k;
        t_idx        lo;
        t_idx        hi;
        issue_command(CMD_CLEAR, t_idx'($urandom), t_idx'($urandom), t_data'($urandom));
        n_adds = $urandom_range(1, 20);
        for (k = 0; k < n_adds; k++) begin
            if ($urandom_range(9) == 0) begin
                issue_noise();
            end else begin
                pick_range(lo, hi);
                issue_command(CMD_ADD, lo, hi, pick_addend());
            end
        end
        // drop the finalize now and then so that the queries are refused
        if ($urandom_range(7) != 0) begin
            issue_command(CMD_FINAL, t_idx'($urandom), t_idx'($urandom), t_data'($urandom));
        end
        n_queries = $urandom_range(1, 15);
        for (k = 0; k < n_queries; k++) begin
            if ($urandom_range(7) == 0) begin
                issue_noise();
            end else begin
                pick_range(lo, hi);
                issue_command(CMD_QUERY, lo, hi, t_data'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        int unsigned phase;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: phase errors, extreme bounds and addends, swapped bounds
        issue_command(CMD_QUERY, 10'd0, 10'd1023, 32'h0);
        issue_command(CMD_ADD, 10'd0, 10'd1023, 32'hFFFF_FFFF);
        issue_command(CMD_ADD, 10'd1023, 10'd0, 32'd5);
        issue_command(CMD_ADD, 10'd0, 10'd0, 32'd1);
        issue_command(CMD_ADD, 10'd1023, 10'd1023, 32'h8000_0000);
        issue_command(CMD_ADD, 10'd511, 10'd512, 32'h1234_5678);
        issue_command(CMD_ADD, 10'd700, 10'd3, 32'h0);
        issue_command(CMD_QUERY, 10'd5, 10'd9, 32'h0);
        issue_command(CMD_FINAL, 10'h3FF, 10'h155, 32'hDEAD_BEEF);
        issue_command(CMD_FINAL, 10'd0, 10'd0, 32'h0);
        issue_command(CMD_ADD, 10'd0, 10'd1023, 32'd7);
        issue_command(CMD_QUERY, 10'd0, 10'd1023, 32'h0);
        issue_command(CMD_QUERY, 10'd1023, 10'd0, 32'hFFFF_FFFF);
        issue_command(CMD_QUERY, 10'd0, 10'd0, 32'h0);
        issue_command(CMD_QUERY, 10'd1023, 10'd1023, 32'h0);
        issue_command(CMD_QUERY, 10'd512, 10'd511, 32'h0);
        issue_command(CMD_QUERY, 10'd3, 10'd700, 32'h0);
        issue_command(CMD_CLEAR, 10'h2AA, 10'h155, 32'hFFFF_FFFF);
        issue_command(CMD_QUERY, 10'd0, 10'd1023, 32'h0);
        issue_command(CMD_CLEAR, 10'd0, 10'd0, 32'h0);
        issue_command(CMD_FINAL, 10'd0, 10'd1023, 32'h0);
        issue_command(CMD_QUERY, 10'd0, 10'd1023, 32'h0);
        issue_command(CMD_CLEAR, 10'h3FF, 10'h3FF, 32'h5555_5555);
        drain_replies();

        // Random rounds under each idling mix, fully drained in between
        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct  = send_pcts[phase];
            recv_stall_pct = recv_pcts[phase];
            items_in_phase = 0;
            while (items_in_phase < PHASE_ITEMS) run_session();
            drain_replies();
        end

        // Watch a while longer for stray results
        recv_stall_pct = 0;
        repeat (200) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
